### sv/svt_pkg.sv
// Shared types and constants for the snapshot version tracker.
// No dependencies; used by svt_ctrl, svt_datapath and snapshot_version_tracker_core.
package svt_pkg;

  localparam int SEQ_W       = 63;
  localparam int MAX_RESULTS = 32;
  localparam int K_W         = $clog2(MAX_RESULTS + 1);

  // command codes (code 3 falls through to query)
  localparam logic [1:0] CMD_REGISTER   = 2'd0;
  localparam logic [1:0] CMD_UNREGISTER = 2'd1;
  localparam logic [1:0] CMD_QUERY      = 2'd2;

  // result status codes
  localparam logic [2:0] STS_OK           = 3'd0;
  localparam logic [2:0] STS_OUT_OF_ORDER = 3'd1;
  localparam logic [2:0] STS_LIST_FULL    = 3'd2;
  localparam logic [2:0] STS_NOT_REG      = 3'd3;
  localparam logic [2:0] STS_BAD_RANGE    = 3'd4;

  typedef struct packed {
    logic [1:0]       command;
    logic [SEQ_W-1:0] seq_value;
    logic [SEQ_W-1:0] next_commit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             removable;
    logic [SEQ_W-1:0] blocking_snapshot;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_REG,
    S_UNR_SRCH,
    S_UNR_SHIFT,
    S_Q_SRCH,
    S_Q_EMIT
  } fsm_state_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_LAST
  } ptr_op_t;

  typedef enum logic {
    WR_APPEND,
    WR_SHIFT
  } wr_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_in;
    ptr_op_t    ptr_op;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       pend_load;
    logic       k_first;
    logic       k_inc;
    logic       emit;
    logic [2:0] emit_status;
    logic       emit_removable;
    logic       emit_snap;
    logic       emit_last;
  } svt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       cnt_zero;
    logic       at_end;
    logic       below_last;
    logic       rd_lt_seq;
    logic       hit;
    logic       bad_range;
    logic       nxt_le_rd;
    logic       rd_gt_nxt;
    logic       dup;
    logic       k_max;
    logic       slot_free;
  } svt_sts_t;

endpackage

### sv/svt_datapath.sv
// Datapath: snapshot list memory, walk pointer, entry count, compares and
// the output register. Depends on svt_pkg; driven by svt_ctrl.
module svt_datapath #(
  parameter int LIST_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  svt_pkg::in_item_t  in_item,
  input  svt_pkg::svt_cmd_t  cmd,
  output svt_pkg::svt_sts_t  sts,
  output logic               out_valid,
  input  logic               out_ready,
  output svt_pkg::out_item_t out_item
);
  import svt_pkg::*;

  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
  localparam logic [K_W-1:0] KMAX_C = K_W'(MAX_RESULTS);

  logic [SEQ_W-1:0] mem [LIST_DEPTH];

  in_item_t         cur;
  logic [CW-1:0]    ptr;
  logic [CW-1:0]    ptr_next;
  logic [CW-1:0]    ptr_prev;
  logic [CW-1:0]    cnt;
  logic [SEQ_W-1:0] rdata;
  logic [SEQ_W-1:0] pending;
  logic [K_W-1:0]   k;
  logic [IW-1:0]    wr_addr;
  logic [SEQ_W-1:0] wr_data;

  always_comb begin
    unique case (cmd.ptr_op)
      PTR_HOLD: ptr_next = ptr;
      PTR_ZERO: ptr_next = '0;
      PTR_INC:  ptr_next = ptr + 1'b1;
      PTR_LAST: ptr_next = cnt - 1'b1;
      default:  ptr_next = ptr;
    endcase
  end

  assign ptr_prev = ptr - 1'b1;

  always_comb begin
    unique case (cmd.wr_sel)
      WR_APPEND: begin
        wr_addr = cnt[IW-1:0];
        wr_data = cur.seq_value;
      end
      WR_SHIFT: begin
        wr_addr = ptr_prev[IW-1:0];
        wr_data = rdata;
      end
      default: begin
        wr_addr = cnt[IW-1:0];
        wr_data = cur.seq_value;
      end
    endcase
  end

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[ptr_next[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.load_in) begin
      cur <= in_item;
    end
    if (cmd.pend_load) begin
      pending <= rdata;
    end
    if (cmd.k_first) begin
      k <= K_W'(1);
    end else if (cmd.k_inc) begin
      k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.status            <= cmd.emit_status;
      out_item.removable         <= cmd.emit_removable;
      out_item.blocking_snapshot <= cmd.emit_snap ? pending : '0;
      out_item.last              <= cmd.emit_last;
    end
  end

  always_comb begin
    sts.command    = cur.command;
    sts.full       = (cnt >= DEPTH_C);
    sts.cnt_zero   = (cnt == '0);
    sts.at_end     = (ptr >= cnt);
    sts.below_last = (cur.seq_value < rdata);
    sts.rd_lt_seq  = (rdata < cur.seq_value);
    sts.hit        = (rdata == cur.seq_value);
    sts.bad_range  = (cur.next_commit <= cur.seq_value);
    sts.nxt_le_rd  = (cur.next_commit <= rdata);
    sts.rd_gt_nxt  = (rdata > cur.next_commit);
    sts.dup        = (rdata == pending);
    sts.k_max      = (k >= KMAX_C);
    sts.slot_free  = !out_valid || out_ready;
  end

endmodule

### sv/svt_ctrl.sv
// Controller state machine for the snapshot version tracker.
// Depends on svt_pkg; drives svt_datapath through svt_cmd_t.
module svt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  svt_pkg::svt_sts_t sts,
  output svt_pkg::svt_cmd_t cmd
);
  import svt_pkg::*;

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.ptr_op = PTR_HOLD;
    cmd.wr_sel = WR_APPEND;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISP;
        end
      end

      S_DISP: begin
        priority case (sts.command)
          CMD_REGISTER: begin
            cmd.ptr_op = PTR_LAST;
            state_next = S_REG;
          end
          CMD_UNREGISTER: begin
            cmd.ptr_op = PTR_ZERO;
            state_next = S_UNR_SRCH;
          end
          default: begin
            cmd.ptr_op = PTR_ZERO;
            state_next = S_Q_SRCH;
          end
        endcase
      end

      S_REG: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
          priority if (sts.full) begin
            cmd.emit_status = STS_LIST_FULL;
          end else if (!sts.cnt_zero && sts.below_last) begin
            cmd.emit_status = STS_OUT_OF_ORDER;
          end else begin
            cmd.emit_status = STS_OK;
            cmd.wr_en       = 1'b1;
            cmd.cnt_inc     = 1'b1;
          end
        end
      end

      S_UNR_SRCH: begin
        priority if (sts.at_end) begin
          if (sts.slot_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = STS_NOT_REG;
            cmd.emit_last   = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (sts.hit) begin
          cmd.ptr_op = PTR_INC;
          state_next = S_UNR_SHIFT;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end

      S_UNR_SHIFT: begin
        if (!sts.at_end) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_SHIFT;
          cmd.ptr_op = PTR_INC;
        end else if (sts.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STS_OK;
          cmd.emit_last   = 1'b1;
          cmd.cnt_dec     = 1'b1;
          state_next      = S_IDLE;
        end
      end

      S_Q_SRCH: begin
        priority if (sts.bad_range) begin
          if (sts.slot_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = STS_BAD_RANGE;
            cmd.emit_last   = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (sts.at_end || (!sts.rd_lt_seq && sts.nxt_le_rd)) begin
          if (sts.slot_free) begin
            cmd.emit           = 1'b1;
            cmd.emit_status    = STS_OK;
            cmd.emit_removable = 1'b1;
            cmd.emit_last      = 1'b1;
            state_next         = S_IDLE;
          end
        end else if (sts.rd_lt_seq) begin
          cmd.ptr_op = PTR_INC;
        end else begin
          cmd.pend_load = 1'b1;
          cmd.k_first   = 1'b1;
          cmd.ptr_op    = PTR_INC;
          state_next    = S_Q_EMIT;
        end
      end

      S_Q_EMIT: begin
        priority if (sts.at_end || sts.rd_gt_nxt || sts.k_max) begin
          if (sts.slot_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = STS_OK;
            cmd.emit_snap   = 1'b1;
            cmd.emit_last   = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (sts.dup) begin
          cmd.ptr_op = PTR_INC;
        end else if (sts.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STS_OK;
          cmd.emit_snap   = 1'b1;
          cmd.pend_load   = 1'b1;
          cmd.k_inc       = 1'b1;
          cmd.ptr_op      = PTR_INC;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/snapshot_version_tracker_core.sv
// Top level of the snapshot version tracker: sorted list of active snapshots.
// Depends on svt_pkg, svt_ctrl and svt_datapath.
//
//  channel | signals                      | payload
//  --------+------------------------------+---------------------------------------
//  in      | in_valid / in_ready          | in_item  (command, seq_value, next_commit)
//  out     | out_valid / out_ready        | out_item (status, removable,
//          |                              |           blocking_snapshot, last)
//
// One item at a time. Accept and dispatch come first, then the walk
// over the list memory runs at one entry per cycle through its single
// registered read port, but for the pauses on the output register below.
// Synchronous active-high reset empties the list (count to zero) at once;
// no clearing pass. A held result in the output register does not block
// accepting the next item; the walk only pauses when it has a new result
// and the output register is still occupied.
module snapshot_version_tracker_core #(
  parameter int LIST_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  svt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output svt_pkg::out_item_t out_item
);
  import svt_pkg::*;

  svt_cmd_t ctl_cmd;  // controller commands
  svt_sts_t dp_sts;   // datapath flags

  svt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  svt_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (ctl_cmd),
    .sts       (dp_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // a result is only written into a free output slot
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.emit |-> dp_sts.slot_free)
    else $error("result written over an untaken output");

  // never append to a full list
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.cnt_inc |-> !dp_sts.full)
    else $error("append on full list");

  // never remove from an empty list
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.cnt_dec |-> !dp_sts.cnt_zero)
    else $error("remove on empty list");

  // final result of an item returns the block to accepting
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (ctl_cmd.emit && ctl_cmd.emit_last) |=> in_ready)
    else $error("block not ready after final result");

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accept");

endmodule
